// File: rtl/core/vertex_transform_perspective_core_defines.svh
// Assertion macros for the vertex transform core.
// No dependencies; included by modules that carry assertions.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_CORE_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_CORE_DEFINES_SVH

// same-cycle implication
`define VTP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/vtp_pkg.sv
// Types and constants for the vertex transform core.
// No dependencies.
`timescale 1ns / 1ps

package vtp_pkg;

  localparam int COORD_W           = 32;
  localparam int CFG_W             = 64;
  localparam int NUM_REGS          = 8;
  localparam int CFG_IDX_W         = 4;
  localparam int SUM_W             = 66;
  localparam int QUO_W             = 33;
  localparam int DEFAULT_FRAC_BITS = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } vtp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      w_was_zero;
    logic                      clipped;
  } vtp_out_t;

endpackage

// File: rtl/core/vertex_transform_perspective_core.sv
// Channel   | signals                              | beat
// in        | in_valid_i / in_ready_o / in_data_i  | one point x, y, z
// out       | out_valid_o / out_ready_i / out_data_o | one transformed point and flags
// cfg       | cfg_we_i / cfg_idx_i / cfg_data_i    | one matrix register
// Stages: capture, multiply, column sum, sign split, 34 restoring divide steps (the
// overflow test, then one quotient bit each), saturate. One beat per cycle unless the output stalls.
// Reset gives the identity matrix and an empty pipeline.
// A stalled output freezes every stage together; nothing is dropped or repeated.
// Depends on vtp_pkg and vertex_transform_perspective_core_defines.svh.
`timescale 1ns / 1ps

`include "vertex_transform_perspective_core_defines.svh"

module vertex_transform_perspective_core #(
  parameter int FRAC_BITS = vtp_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  vtp_pkg::vtp_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output vtp_pkg::vtp_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vtp_pkg::CFG_W-1:0]      cfg_data_i
);
  import vtp_pkg::*;

  localparam int NW    = SUM_W + FRAC_BITS;
  localparam int DW    = SUM_W;
  localparam int CW    = (NW > DW + QUO_W) ? NW + 1 : DW + QUO_W + 1;
  localparam int DSTG  = QUO_W + 1;
  localparam int NSTG  = 4 + DSTG + 1;
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0] regs_q [NUM_REGS];
  logic signed [COORD_W-1:0] mat [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
      regs_q[0] <= ONE;
      regs_q[2] <= ONE << COORD_W;
      regs_q[5] <= ONE;
      regs_q[7] <= ONE << COORD_W;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs_q[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
      end
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_q, vld_d;
  logic            adv;

  assign adv        = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // capture
  logic signed [COORD_W-1:0] pt_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[0] <= in_data_i.in_x;
      pt_q[1] <= in_data_i.in_y;
      pt_q[2] <= in_data_i.in_z;
    end
  end

  // multiply
  logic signed [2*COORD_W-1:0] prod_q [4][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= pt_q[r] * mat[r][c];
        end
      end
    end
  end

  // column sums
  logic signed [SUM_W-1:0] sum_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= (SUM_W'(mat[3][c]) <<< FRAC_BITS) + SUM_W'(prod_q[c][0])
                  + SUM_W'(prod_q[c][1]) + SUM_W'(prod_q[c][2]);
      end
    end
  end

  // divider pipeline, index 0 is the sign split register
  logic [NW-1:0]    rem_q [DSTG+1][3];
  logic [QUO_W-1:0] quo_q [DSTG+1][3];
  logic             ovf_q [DSTG+1][3];
  logic             neg_q [DSTG+1][3];
  logic [DW-1:0]    den_q [DSTG+1];
  logic             wz_q  [DSTG+1];

  logic             w_neg, w_zero;
  logic [DW-1:0]    w_mag;

  assign w_neg  = sum_q[3][SUM_W-1];
  assign w_zero = (sum_q[3] == '0);
  assign w_mag  = w_neg ? DW'(-sum_q[3]) : DW'(sum_q[3]);

  always_ff @(posedge clk_i) begin
    logic          s_neg;
    logic [DW-1:0] s_mag;
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s_neg          = sum_q[c][SUM_W-1];
        s_mag          = s_neg ? DW'(-sum_q[c]) : DW'(sum_q[c]);
        rem_q[0][c]   <= w_zero ? NW'(s_mag) : (NW'(s_mag) << FRAC_BITS);
        quo_q[0][c]   <= '0;
        ovf_q[0][c]   <= 1'b0;
        neg_q[0][c]   <= w_zero ? s_neg : (s_neg ^ w_neg);
      end
      den_q[0] <= w_zero ? (DW'(1) << FRAC_BITS) : w_mag;
      wz_q[0]  <= w_zero;
    end
  end

  for (genvar j = 0; j < DSTG; j++) begin : g_div
    localparam int K = (j == 0) ? QUO_W : QUO_W - j;
    logic [CW:0] dsh;
    logic [CW:0] diff [3];

    assign dsh = (CW+1)'(den_q[j]) << K;

    for (genvar c = 0; c < 3; c++) begin : g_lane
      assign diff[c] = (CW+1)'(rem_q[j][c]) - dsh;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          neg_q[j+1][c] <= neg_q[j][c];
          if (j == 0) begin
            rem_q[j+1][c] <= rem_q[j][c];
            quo_q[j+1][c] <= quo_q[j][c];
            ovf_q[j+1][c] <= !diff[c][CW];
          end else begin
            ovf_q[j+1][c] <= ovf_q[j][c];
            if (!diff[c][CW]) begin
              rem_q[j+1][c] <= diff[c][NW-1:0];
              quo_q[j+1][c] <= quo_q[j][c] | (QUO_W'(1) << K);
            end else begin
              rem_q[j+1][c] <= rem_q[j][c];
              quo_q[j+1][c] <= quo_q[j][c];
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q[j+1] <= den_q[j];
        wz_q[j+1]  <= wz_q[j];
      end
    end
  end

  // saturate
  localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32'h7FFF_FFFF);
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(33'h0_8000_0000);

  logic [COORD_W-1:0] res [3];
  logic [2:0]         sat;
  vtp_out_t           out_q;

  always_comb begin
    logic [QUO_W-1:0] q;
    logic             nf;
    for (int c = 0; c < 3; c++) begin
      q      = quo_q[DSTG][c];
      nf     = neg_q[DSTG][c] && (q != '0);
      sat[c] = ovf_q[DSTG][c] || (nf ? (q > NEG_LIM) : (q > POS_LIM));
      if (sat[c]) begin
        res[c] = nf ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res[c] = nf ? (COORD_W'(0) - q[COORD_W-1:0]) : q[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_x      <= res[0];
      out_q.out_y      <= res[1];
      out_q.out_z      <= res[2];
      out_q.w_was_zero <= wz_q[DSTG];
      out_q.clipped    <= |sat;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = out_q;

  `VTP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !adv, $stable(vld_q), "pipeline moved while stalled")
  `VTP_ASSERT_NEXT(a_enter, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0], "accepted beat lost at entry")
  `VTP_ASSERT_NOW(a_clip_val, clk_i, rst_ni, out_valid_o && out_data_o.clipped, (out_data_o.out_x == 32'sh7FFF_FFFF) || (out_data_o.out_x == 32'sh8000_0000) || (out_data_o.out_y == 32'sh7FFF_FFFF) || (out_data_o.out_y == 32'sh8000_0000) || (out_data_o.out_z == 32'sh7FFF_FFFF) || (out_data_o.out_z == 32'sh8000_0000), "clip flag without saturated value")

endmodule
